// ===== design/rgbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbc_pkg: shared types and constants of the RGBC colour classifier
// Register map, reset values, class codes and the limit bundle passed between
// modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbc_pkg;

  localparam int CountW = 16;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  // Register byte addresses.
  localparam logic [AddrW-1:0] AddrDark   = 5'd0;
  localparam logic [AddrW-1:0] AddrGold   = 5'd4;
  localparam logic [AddrW-1:0] AddrWhite  = 5'd8;
  localparam logic [AddrW-1:0] AddrSilver = 5'd12;
  localparam logic [AddrW-1:0] AddrGray   = 5'd16;

  // Reset values of the limits.
  localparam logic [CountW-1:0] DarkReset   = 16'd30;
  localparam logic [CountW-1:0] GoldReset   = 16'd400;
  localparam logic [CountW-1:0] WhiteReset  = 16'd600;
  localparam logic [CountW-1:0] SilverReset = 16'd300;
  localparam logic [CountW-1:0] GrayReset   = 16'd80;

  // Colour class codes carried in the result transaction.
  typedef enum logic [3:0] {
    ClsNone    = 4'd0,
    ClsOrange  = 4'd1,
    ClsRed     = 4'd2,
    ClsGold    = 4'd3,
    ClsYellow  = 4'd4,
    ClsGreen   = 4'd5,
    ClsBlue    = 4'd6,
    ClsViolet  = 4'd7,
    ClsWhite   = 4'd8,
    ClsSilver  = 4'd9,
    ClsGray    = 4'd10,
    ClsUnknown = 4'd11
  } color_class_t;

  typedef struct packed {
    logic [CountW-1:0] dark_limit;
    logic [CountW-1:0] gold_limit;
    logic [CountW-1:0] white_limit;
    logic [CountW-1:0] silver_limit;
    logic [CountW-1:0] gray_limit;
  } limits_t;

endpackage

`default_nettype wire

// ===== design/rgbc_color_classifier_core.sv =====
// ----------------------------------------------------------------------------
// rgbc_color_classifier_core: RGBC colour class pipeline
// Classifies one red/green/blue/clear sample per transaction into a class.
// ----------------------------------------------------------------------------
// The block takes one sensor sample per input transaction and returns exactly
// one colour class per sample, in order. It is a four-stage pipeline: the
// first stage registers the counts, their sum and the clear-level compares;
// the second forms every constant product needed for the ratio tests; the
// third does the cross-multiplied comparisons; the output register resolves
// the priority chain. A new sample can be accepted on every clock cycle
// unless a stall on the output has filled the pipeline. Each stage has its own
// valid bit and only holds when the stage after it is full and stalled, so
// bubbles are squeezed out and a stall on the output loses or repeats nothing.
// The user must write the limits through the APB-style port only while no
// transaction is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module rgbc_color_classifier_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Sample input: red_count [15:0], green_count [31:16],
  // blue_count [47:32], clear_count [63:48].
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [63:0]                s_tdata,
  // Result output: color_class [3:0], zeros above.
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [7:0]                 m_tdata,
  // Configuration port.
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rgbc_pkg::AddrW-1:0] paddr,
  input  wire logic [rgbc_pkg::DataW-1:0] pwdata,
  output logic      [rgbc_pkg::DataW-1:0] prdata,
  output logic                            pready
);

  // Clear-level compares travel together down the pipeline.
  typedef struct packed {
    logic dark;
    logic gold;
    logic white;
    logic silver;
    logic gray;
  } level_t;

  rgbc_pkg::limits_t limits;

  rgbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  // Stage enables: a stage loads when it is empty or the next one loads.
  logic v_a, v_b, v_c;
  logic en_a, en_b, en_c, en_o;

  assign en_o     = !m_tvalid || m_tready;
  assign en_c     = !v_c || en_o;
  assign en_b     = !v_b || en_c;
  assign en_a     = !v_a || en_b;
  assign s_tready = en_a;

  // ---------------------------------------------------------------- stage A
  logic [15:0] in_r, in_g, in_b, in_c;
  level_t      lvl_in;

  assign in_r = s_tdata[15:0];
  assign in_g = s_tdata[31:16];
  assign in_b = s_tdata[47:32];
  assign in_c = s_tdata[63:48];

  assign lvl_in.dark   = in_c < limits.dark_limit;
  assign lvl_in.gold   = in_c > limits.gold_limit;
  assign lvl_in.white  = in_c > limits.white_limit;
  assign lvl_in.silver = in_c > limits.silver_limit;
  assign lvl_in.gray   = in_c > limits.gray_limit;

  logic [15:0] a_r, a_g, a_b;
  logic [17:0] a_t;
  level_t      a_lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (en_a) begin
      v_a <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && s_tvalid) begin
      a_r   <= in_r;
      a_g   <= in_g;
      a_b   <= in_b;
      a_t   <= 18'(in_r) + 18'(in_g) + 18'(in_b);
      a_lvl <= lvl_in;
    end
  end

  // ---------------------------------------------------------------- stage B
  // Constant products for the cross-multiplied ratio tests.
  logic [15:0] a_drg, a_dgb;

  assign a_drg = (a_r > a_g) ? (a_r - a_g) : (a_g - a_r);
  assign a_dgb = (a_g > a_b) ? (a_g - a_b) : (a_b - a_g);

  logic [20:0] b_r20, b_g23, b_g17;
  logic [22:0] b_b100, b_t23;
  logic [18:0] b_b5, b_t2;
  logic [19:0] b_r10, b_g10, b_t3;
  logic [20:0] b_drg20, b_dgb20;
  logic        b_gzero, b_tzero, b_gdom, b_bdom;
  level_t      b_lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (en_b) begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && v_a) begin
      b_r20   <= 21'(a_r) * 21'd20;
      b_g23   <= 21'(a_g) * 21'd23;
      b_g17   <= 21'(a_g) * 21'd17;
      b_b100  <= 23'(a_b) * 23'd100;
      b_t23   <= 23'(a_t) * 23'd23;
      b_b5    <= 19'(a_b) * 19'd5;
      b_t2    <= {a_t, 1'b0};
      b_r10   <= 20'(a_r) * 20'd10;
      b_g10   <= 20'(a_g) * 20'd10;
      b_t3    <= 20'(a_t) * 20'd3;
      b_drg20 <= 21'(a_drg) * 21'd20;
      b_dgb20 <= 21'(a_dgb) * 21'd20;
      b_gzero <= a_g == 16'd0;
      b_tzero <= a_t == 18'd0;
      b_gdom  <= (a_g > a_r) && (a_g > a_b);
      b_bdom  <= (a_b > a_r) && (a_b > a_g);
      b_lvl   <= a_lvl;
    end
  end

  // ---------------------------------------------------------------- stage C
  // Ratio tests resolved to single flags.
  logic   c_tzero, c_high, c_orange, c_mid, c_gdom, c_bdom, c_violet, c_bal;
  level_t c_lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else if (en_c) begin
      v_c <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && v_b) begin
      c_tzero  <= b_tzero;
      c_high   <= b_gzero || (b_r20 > b_g23);
      c_orange <= b_b100 < b_t23;
      c_mid    <= b_r20 > b_g17;
      c_gdom   <= b_gdom;
      c_bdom   <= b_bdom;
      c_violet <= (b_b5 > b_t2) && (b_r10 > b_t3) && (b_g10 < b_t3);
      c_bal    <= (b_drg20 < 21'(b_t3)) && (b_dgb20 < 21'(b_t3));
      c_lvl    <= b_lvl;
    end
  end

  // ---------------------------------------------------------------- output
  // Priority chain: the first test that matches decides the class.
  logic [3:0] cls_next;

  always_comb begin
    if (c_lvl.dark || c_tzero) begin
      cls_next = rgbc_pkg::ClsNone;
    end else if (c_high) begin
      cls_next = c_orange ? rgbc_pkg::ClsOrange : rgbc_pkg::ClsRed;
    end else if (c_mid) begin
      cls_next = c_lvl.gold ? rgbc_pkg::ClsGold : rgbc_pkg::ClsYellow;
    end else if (c_gdom) begin
      cls_next = rgbc_pkg::ClsGreen;
    end else if (c_bdom) begin
      cls_next = rgbc_pkg::ClsBlue;
    end else if (c_violet) begin
      cls_next = rgbc_pkg::ClsViolet;
    end else if (c_bal && c_lvl.white) begin
      cls_next = rgbc_pkg::ClsWhite;
    end else if (c_bal && c_lvl.silver) begin
      cls_next = rgbc_pkg::ClsSilver;
    end else if (c_bal && c_lvl.gray) begin
      cls_next = rgbc_pkg::ClsGray;
    end else begin
      cls_next = rgbc_pkg::ClsUnknown;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_o) begin
      m_tvalid <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && v_c) begin
      m_tdata <= {4'd0, cls_next};
    end
  end

endmodule

`default_nettype wire

// ===== design/rgbc_regs.sv =====
// ----------------------------------------------------------------------------
// rgbc_regs: configuration register file
// Holds the five clear-level limits behind a simple APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rgbc_pkg::AddrW-1:0]    paddr,
  input  wire logic [rgbc_pkg::DataW-1:0]    pwdata,
  output logic      [rgbc_pkg::DataW-1:0]    prdata,
  output logic                               pready,
  output rgbc_pkg::limits_t                  limits
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.dark_limit   <= rgbc_pkg::DarkReset;
      limits.gold_limit   <= rgbc_pkg::GoldReset;
      limits.white_limit  <= rgbc_pkg::WhiteReset;
      limits.silver_limit <= rgbc_pkg::SilverReset;
      limits.gray_limit   <= rgbc_pkg::GrayReset;
    end else if (wr_en) begin
      unique case (paddr)
        rgbc_pkg::AddrDark:   limits.dark_limit   <= pwdata[rgbc_pkg::CountW-1:0];
        rgbc_pkg::AddrGold:   limits.gold_limit   <= pwdata[rgbc_pkg::CountW-1:0];
        rgbc_pkg::AddrWhite:  limits.white_limit  <= pwdata[rgbc_pkg::CountW-1:0];
        rgbc_pkg::AddrSilver: limits.silver_limit <= pwdata[rgbc_pkg::CountW-1:0];
        rgbc_pkg::AddrGray:   limits.gray_limit   <= pwdata[rgbc_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr)
      rgbc_pkg::AddrDark:   prdata = {16'd0, limits.dark_limit};
      rgbc_pkg::AddrGold:   prdata = {16'd0, limits.gold_limit};
      rgbc_pkg::AddrWhite:  prdata = {16'd0, limits.white_limit};
      rgbc_pkg::AddrSilver: prdata = {16'd0, limits.silver_limit};
      rgbc_pkg::AddrGray:   prdata = {16'd0, limits.gray_limit};
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/rgbc_color_classifier_core_tb.sv =====
// ----------------------------------------------------------------------------
// rgbc_color_classifier_core_tb: self-checking bench for the colour classifier
// Streams sensor samples through the core and checks every colour class
// against a cycle-free prediction, across several sets of limit registers.
// ----------------------------------------------------------------------------
// The bench drives red/green/blue/clear samples on the slave stream and
// collects colour classes on the master stream. A monitor works out the
// expected class for every sample transaction the moment it is accepted, using
// a copy of the limit registers that is updated whenever the bench writes one,
// and queues it. Each result transaction is then compared with the oldest
// queued class. The limits are only written once the pipeline has drained.
//
// Both sides idle at random: mostly short gaps, now and then a long one, and
// some stretches run flat out. One test holds the result side off for a long
// stretch so that the pipeline fills up and pushes back on the sample side.
`timescale 1ns / 1ps
`default_nettype none

module rgbc_color_classifier_core_tb;

  localparam int ClkHalf   = 5;
  localparam int PipeDepth = 4;   // registered stages between a sample and its result
  localparam int LongHold  = 300; // cycles the result side stays blocked

  // Address that lies beyond the limit registers; writes there must be dropped.
  localparam logic [rgbc_pkg::AddrW-1:0] AddrUnused = 5'd20;

  // One sensor sample, laid out exactly as on s_tdata (red in the lowest bits).
  typedef struct packed {
    logic [rgbc_pkg::CountW-1:0] clear;
    logic [rgbc_pkg::CountW-1:0] blue;
    logic [rgbc_pkg::CountW-1:0] green;
    logic [rgbc_pkg::CountW-1:0] red;
  } sample_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [63:0]                s_tdata;   // red_count, green_count, blue_count, clear_count
  logic                       m_tvalid;
  logic                       m_tready;
  logic [7:0]                 m_tdata;   // color_class, zero padding
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [rgbc_pkg::AddrW-1:0] paddr;
  logic [rgbc_pkg::DataW-1:0] pwdata;
  logic [rgbc_pkg::DataW-1:0] prdata;
  logic                       pready;

  // The bench's own copy of the limit registers, kept in step with every write.
  rgbc_pkg::limits_t      limits;
  // Classes predicted for accepted samples and not yet seen on the output.
  rgbc_pkg::color_class_t pending_classes[$];

  int          error_count   = 0;
  int          samples_taken = 0;
  int          classes_seen[12];
  bit          steady_flow   = 1'b0;  // when set, neither side inserts gaps
  int unsigned long_hold_req = 0;     // hold-off request picked up by the receiver

  rgbc_color_classifier_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #ClkHalf clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Priority chain of the classifier. Every ratio test is done as an exact
  // integer cross-multiplication, so nothing is rounded. A zero green count is
  // treated as an unbounded red-to-green ratio.
  function automatic rgbc_pkg::color_class_t predict_class(sample_t smp);
    int unsigned r, g, b, c, sum, d_rg, d_gb;
    r    = smp.red;
    g    = smp.green;
    b    = smp.blue;
    c    = smp.clear;
    sum  = r + g + b;
    d_rg = (r > g) ? r - g : g - r;
    d_gb = (g > b) ? g - b : b - g;
    if (c < limits.dark_limit) return rgbc_pkg::ClsNone;
    if (sum == 0) return rgbc_pkg::ClsNone;
    // Red-to-green ratio above 1.15: orange when blue is under 23 % of the sum.
    if (g == 0 || 20 * r > 23 * g)
      return (100 * b < 23 * sum) ? rgbc_pkg::ClsOrange : rgbc_pkg::ClsRed;
    // Ratio between 0.85 and 1.15: the clear level splits gold from yellow.
    if (20 * r > 17 * g)
      return (c > limits.gold_limit) ? rgbc_pkg::ClsGold : rgbc_pkg::ClsYellow;
    if (g > r && g > b) return rgbc_pkg::ClsGreen;
    if (b > r && b > g) return rgbc_pkg::ClsBlue;
    if (5 * b > 2 * sum && 10 * r > 3 * sum && 10 * g < 3 * sum) return rgbc_pkg::ClsViolet;
    // Balanced channels: the clear level picks white, silver or gray.
    if (20 * d_rg < 3 * sum && 20 * d_gb < 3 * sum) begin
      if (c > limits.white_limit) return rgbc_pkg::ClsWhite;
      if (c > limits.silver_limit) return rgbc_pkg::ClsSilver;
      if (c > limits.gray_limit) return rgbc_pkg::ClsGray;
    end
    return rgbc_pkg::ClsUnknown;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and checker
  // --------------------------------------------------------------------------

  // Both streams are sampled at the clock edge, before any of the bench's
  // nonblocking updates of that edge have landed.
  always @(posedge clk) begin
    rgbc_pkg::color_class_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pending_classes.push_back(predict_class(sample_t'(s_tdata)));
        samples_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (pending_classes.size() == 0) begin
          $display("%0t: result transaction with nothing expected, got class %0d",
                   $time, m_tdata);
          error_count++;
        end else begin
          want = pending_classes.pop_front();
          classes_seen[want]++;
          if (m_tdata !== {4'b0000, want}) begin
            $display("%0t: colour class mismatch, expected %0d, got %0d",
                     $time, want, m_tdata);
            error_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Idle gaps and the result side
  // --------------------------------------------------------------------------

  // Most gaps are zero, some are short and a handful are long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiver stalls at random and honours a long hold-off on request,
  // counting the stalled cycles itself.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req != 0) begin
        stall_left    = long_hold_req;
        long_hold_req = 0;
      end
      if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        if (stall_left != 0) begin
          m_tready <= 1'b0;
          stall_left--;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sample side
  // --------------------------------------------------------------------------

  function automatic sample_t counts(int unsigned r, int unsigned g, int unsigned b,
                                     int unsigned c);
    sample_t smp;
    smp.red   = r[15:0];
    smp.green = g[15:0];
    smp.blue  = b[15:0];
    smp.clear = c[15:0];
    return smp;
  endfunction

  // Offers one sample transaction after a random gap and returns at the edge
  // where it is taken. s_tvalid stays high for a back-to-back follower.
  task automatic send_sample(sample_t smp);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Lowers the sample side and waits until every predicted class has come
  // out, then lets the pipeline settle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_classes.size() != 0) @(posedge clk);
    repeat (PipeDepth + 2) @(posedge clk);
  endtask

  // A clear count that often sits right on one of the current limits.
  function automatic logic [15:0] pick_clear();
    logic [15:0] lim_val;
    case ($urandom_range(0, 4))
      0:       lim_val = limits.dark_limit;
      1:       lim_val = limits.gold_limit;
      2:       lim_val = limits.white_limit;
      3:       lim_val = limits.silver_limit;
      default: lim_val = limits.gray_limit;
    endcase
    case ($urandom_range(0, 5))
      0:       return lim_val - 16'd1;
      1:       return lim_val;
      2:       return lim_val + 16'd1;
      3:       return 16'($urandom_range(0, 1000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Random samples, shaped so that each branch of the priority chain and the
  // edges of its ratio tests are reached often.
  function automatic sample_t make_sample();
    sample_t smp;
    int      base, spread;
    smp = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: ;  // fully random counts
      2, 3: begin
        // Red close to 1.15 or 0.85 times green.
        base      = $urandom_range(1, 50000);
        smp.green = base[15:0];
        if ($urandom_range(0, 1))
          smp.red = 16'((base * 23) / 20 + $urandom_range(0, 2) - 1);
        else
          smp.red = 16'((base * 17) / 20 + $urandom_range(0, 2) - 1);
        smp.blue  = 16'($urandom_range(0, base));
      end
      4, 5: begin
        // Three channels of nearly equal level.
        base      = $urandom_range(1, 20000);
        spread    = base / 6;
        smp.red   = 16'(base + $urandom_range(0, 2 * spread) - spread);
        smp.green = 16'(base + $urandom_range(0, 2 * spread) - spread);
        smp.blue  = 16'(base + $urandom_range(0, 2 * spread) - spread);
      end
      6: begin
        // One strong channel over two weak ones.
        smp.red   = 16'($urandom_range(0, 200));
        smp.green = 16'($urandom_range(0, 200));
        smp.blue  = 16'($urandom_range(0, 200));
        case ($urandom_range(0, 2))
          0:       smp.red   = 16'($urandom);
          1:       smp.green = 16'($urandom);
          default: smp.blue  = 16'($urandom);
        endcase
      end
      7: begin
        // Some channels at zero.
        smp.red   = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 2000));
        smp.green = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 2000));
        smp.blue  = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 2000));
      end
      default: begin
        smp.red   = 16'($urandom_range(0, 1000));
        smp.green = 16'($urandom_range(0, 1000));
        smp.blue  = 16'($urandom_range(0, 1000));
      end
    endcase
    if ($urandom_range(0, 4) != 0) smp.clear = pick_clear();
    return smp;
  endfunction

  // Sends a batch of random samples; now and then a stretch runs with no gaps.
  task automatic run_random_samples(int num);
    for (int i = 0; i < num; i++) begin
      if (i % 100 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      send_sample(make_sample());
    end
    steady_flow = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------

  function automatic logic [rgbc_pkg::AddrW-1:0] limit_addr(int idx);
    case (idx)
      0:       return rgbc_pkg::AddrDark;
      1:       return rgbc_pkg::AddrGold;
      2:       return rgbc_pkg::AddrWhite;
      3:       return rgbc_pkg::AddrSilver;
      default: return rgbc_pkg::AddrGray;
    endcase
  endfunction

  function automatic logic [15:0] limit_value(logic [rgbc_pkg::AddrW-1:0] addr);
    case (addr)
      rgbc_pkg::AddrDark:   return limits.dark_limit;
      rgbc_pkg::AddrGold:   return limits.gold_limit;
      rgbc_pkg::AddrWhite:  return limits.white_limit;
      rgbc_pkg::AddrSilver: return limits.silver_limit;
      default:              return limits.gray_limit;
    endcase
  endfunction

  // Reads one limit register back and compares it with the bench's copy.
  task automatic check_readback(logic [rgbc_pkg::AddrW-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== limit_value(addr)) begin
      $display("%0t: limit at address %0d reads back wrong, expected %0d, got %0d",
               $time, addr, limit_value(addr), prdata[15:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes one limit (with junk above bit 15, which the block must drop),
  // mirrors it in the bench's copy and reads it back unless the address is unused.
  task automatic write_limit(logic [rgbc_pkg::AddrW-1:0] addr, logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      rgbc_pkg::AddrDark:   limits.dark_limit   = value;
      rgbc_pkg::AddrGold:   limits.gold_limit   = value;
      rgbc_pkg::AddrWhite:  limits.white_limit  = value;
      rgbc_pkg::AddrSilver: limits.silver_limit = value;
      rgbc_pkg::AddrGray:   limits.gray_limit   = value;
      default:              ;
    endcase
    @(posedge clk);
    if (addr != AddrUnused) check_readback(addr);
  endtask

  task automatic write_all_limits(logic [15:0] dark, logic [15:0] gold,
                                  logic [15:0] white, logic [15:0] silver,
                                  logic [15:0] gray);
    write_limit(rgbc_pkg::AddrDark, dark);
    write_limit(rgbc_pkg::AddrGold, gold);
    write_limit(rgbc_pkg::AddrWhite, white);
    write_limit(rgbc_pkg::AddrSilver, silver);
    write_limit(rgbc_pkg::AddrGray, gray);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_reset_values();
    for (int i = 0; i < 5; i++) check_readback(limit_addr(i));
  endtask

  // Hand-picked samples under the reset limits: each branch of the chain and
  // both sides of every boundary that can be hit. The violet test can never
  // pass, since it needs red above green while the mid-ratio test has
  // already taken every such sample.
  task automatic test_directed();
    send_sample(counts(0, 0, 0, 1000));              // all channels zero
    send_sample(counts(100, 100, 100, 29));          // clear just under dark limit
    send_sample(counts(100, 100, 100, 30));          // clear on dark limit: yellow
    send_sample(counts(100, 0, 0, 500));             // green zero, no blue: orange
    send_sample(counts(1, 0, 1000, 500));            // green zero, strong blue: red
    send_sample(counts(24, 20, 0, 500));             // just above 1.15, orange
    send_sample(counts(24, 20, 100, 500));           // just above 1.15, red
    send_sample(counts(23, 20, 0, 401));             // exactly 1.15, bright: gold
    send_sample(counts(23, 20, 0, 400));             // exactly 1.15, on gold limit: yellow
    send_sample(counts(57, 20, 23, 500));            // blue exactly 23 % of sum: red
    send_sample(counts(58, 20, 22, 500));            // blue under 23 %: orange
    send_sample(counts(17, 20, 0, 500));             // exactly 0.85: falls to green
    send_sample(counts(50, 100, 300, 500));          // blue dominant
    send_sample(counts(85, 100, 100, 601));          // balanced, white
    send_sample(counts(85, 100, 100, 600));          // on white limit: silver
    send_sample(counts(85, 100, 100, 301));          // silver
    send_sample(counts(85, 100, 100, 300));          // on silver limit: gray
    send_sample(counts(85, 100, 100, 81));           // gray
    send_sample(counts(85, 100, 100, 80));           // on gray limit: unknown
    send_sample(counts(0, 100, 100, 1000));          // neither dominant nor balanced
    send_sample(counts(65535, 65535, 65535, 65535)); // all full scale: gold
    send_sample(counts(0, 65535, 0, 65535));         // green only
    send_sample(counts(0, 0, 65535, 65535));         // blue only
    send_sample(counts(65535, 1, 65535, 0));         // dark at full colour
    wait_drained();
  endtask

  task automatic test_random_reset_limits();
    run_random_samples(500);
    wait_drained();
  endtask

  // Every limit at zero (nothing is dark), then every limit at full scale
  // (nearly everything is dark).
  task automatic test_limit_extremes();
    write_all_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random_samples(250);
    wait_drained();
    write_all_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random_samples(250);
    wait_drained();
  endtask

  task automatic test_random_limits();
    logic [15:0] vals[5];
    for (int round = 0; round < 4; round++) begin
      foreach (vals[i])
        vals[i] = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 1000))
                                              : 16'($urandom);
      write_all_limits(vals[0], vals[1], vals[2], vals[3], vals[4]);
      run_random_samples(150);
      wait_drained();
    end
  endtask

  // Band limits in the wrong order: they are still applied white first.
  task automatic test_unordered_limits();
    write_all_limits(16'd10, 16'd0, 16'd50, 16'd500, 16'd2000);
    run_random_samples(150);
    wait_drained();
  endtask

  // A write to an address past the register map must change nothing.
  task automatic test_unused_address();
    write_limit(AddrUnused, 16'($urandom));
    for (int i = 0; i < 5; i++) check_readback(limit_addr(i));
    run_random_samples(50);
    wait_drained();
  endtask

  // The result side is blocked for a long stretch while samples keep coming,
  // so the pipeline fills and stalls its input. Afterwards the sample side
  // pauses until every result is out before a second burst.
  task automatic test_backpressure();
    write_all_limits(rgbc_pkg::DarkReset, rgbc_pkg::GoldReset, rgbc_pkg::WhiteReset,
                     rgbc_pkg::SilverReset, rgbc_pkg::GrayReset);
    long_hold_req = LongHold;
    steady_flow   = 1'b1;
    for (int i = 0; i < 60; i++) send_sample(make_sample());
    steady_flow   = 1'b0;
    wait_drained();
    run_random_samples(40);
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    int kinds;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    limits.dark_limit   = rgbc_pkg::DarkReset;
    limits.gold_limit   = rgbc_pkg::GoldReset;
    limits.white_limit  = rgbc_pkg::WhiteReset;
    limits.silver_limit = rgbc_pkg::SilverReset;
    limits.gray_limit   = rgbc_pkg::GrayReset;
    foreach (classes_seen[i]) classes_seen[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_directed();
    test_random_reset_limits();
    test_limit_extremes();
    test_random_limits();
    test_unordered_limits();
    test_unused_address();
    test_backpressure();

    kinds = 0;
    foreach (classes_seen[i]) if (classes_seen[i] != 0) kinds++;
    $display("Classified %0d samples under reset, extreme, random and unordered limits,",
             samples_taken);
    $display("with %0d of the 12 colour classes produced, plus stalls on both streams.",
             kinds);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
